>>> rtl/slaf_pkg.sv
// Package for the slew-limited eight-sample average filter.
// Widths, reset values, opcodes and register addresses shared by all rtl/ files.
// No dependencies.
package slaf_pkg;

  // Field widths fixed by the interface
  localparam int FIELD_W       = 16;
  localparam int SLEW_W        = 16;
  localparam int SAMPLE_BITS_D = 16;

  // History depth (the newest sample makes the eighth term)
  localparam int HIST_DEPTH = 7;

  localparam logic [SLEW_W-1:0] SLEW_RESET = 16'd20;

  // Opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_RELOAD = 1'b1;

  // Configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;
  localparam logic SEL_SLEW = 1'b0;  // paddr[2] selects the register word

  typedef struct packed {
    logic               opcode;
    logic [FIELD_W-1:0] sample;
  } item_t;

endpackage

>>> rtl/slew_limited_average_filter_core.sv
// Top level of the slew-limited eight-sample average filter.
// Depends on slaf_pkg, slaf_cfg and slaf_core.
//
// Use:
//   Input channel (in_valid, in_stall, opcode, sample): a word is taken at a
//   rising edge with in_valid high and in_stall low. opcode OP_SAMPLE filters
//   the sample; OP_RELOAD arms a reload and gives no output word.
//   Output channel (out_valid, out_stall, filtered): a word leaves at a rising
//   edge with out_valid high and out_stall low.
//   Path: a taken sample passes the input register, then the output
//   register, and waits in the input register while the output word stalls.
//   One word per cycle while no output word stalls; the clamp, the eight-term
//   sum and the rounding all settle in the single stage between the registers.
//   Stall: while the output word waits, the input register still takes one
//   word and reload requests keep moving; a sample is held in the input
//   register, with in_stall high, until the output register frees.
//   Reset (rst, synchronous): channels empty, history and last output zero,
//   slew_limit 20, reload armed so the first sample refills history. Users must
//   write slew_limit over the APB-style port only while idle; not enforced.
module slew_limited_average_filter_core #(
  parameter int SAMPLE_BITS = slaf_pkg::SAMPLE_BITS_D
) (
  input  logic                          clk,
  input  logic                          rst,
  // input words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [slaf_pkg::FIELD_W-1:0]  sample,
  // output words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [slaf_pkg::FIELD_W-1:0]  filtered,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slaf_pkg::APB_AW-1:0]   paddr,
  input  logic [slaf_pkg::APB_DW-1:0]   pwdata,
  output logic [slaf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  logic [slaf_pkg::SLEW_W-1:0]  slew_limit;

  // Input register
  logic                         in_full;
  slaf_pkg::item_t              in_word;

  logic                         out_free;
  logic                         fire;
  logic [slaf_pkg::FIELD_W-1:0] result;

  slaf_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .slew_limit (slew_limit)
  );

  // A reload request needs no output slot; a sample needs a free output register
  assign out_free = !out_valid || !out_stall;
  assign fire     = in_full && ((in_word.opcode == slaf_pkg::OP_RELOAD) || out_free);
  assign in_stall = in_full && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  // Payload: load on accept, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word.opcode <= opcode;
      in_word.sample <= sample;
    end
  end

  slaf_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (in_word),
    .slew_limit (slew_limit),
    .result     (result)
  );

  // Output register: advance on a finished sample, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && (in_word.opcode == slaf_pkg::OP_SAMPLE)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (in_word.opcode == slaf_pkg::OP_SAMPLE)) begin
      filtered <= result;
    end
  end

endmodule

>>> rtl/slaf_cfg.sv
// Configuration register block: APB-style slave holding slew_limit.
// Depends on slaf_pkg.
module slaf_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slaf_pkg::APB_AW-1:0]   paddr,
  input  logic [slaf_pkg::APB_DW-1:0]   pwdata,
  output logic [slaf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [slaf_pkg::SLEW_W-1:0]   slew_limit
);

  logic wr_slew;

  assign pready  = 1'b1;
  assign wr_slew = psel && penable && pwrite && (paddr[2] == slaf_pkg::SEL_SLEW);

  always_ff @(posedge clk) begin
    if (rst) begin
      slew_limit <= slaf_pkg::SLEW_RESET;
    end else if (wr_slew) begin
      slew_limit <= pwdata[slaf_pkg::SLEW_W-1:0];
    end
  end

  // Unused word reads as zero
  assign prdata = (paddr[2] == slaf_pkg::SEL_SLEW) ?
                  slaf_pkg::APB_DW'(slew_limit) : '0;

endmodule

>>> rtl/slaf_core.sv
// Filter state and arithmetic: slew clamp, eight-term sum, rounded divide by eight.
// Depends on slaf_pkg.
module slaf_core #(
  parameter int SAMPLE_BITS = slaf_pkg::SAMPLE_BITS_D
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  slaf_pkg::item_t              item,
  input  logic [slaf_pkg::SLEW_W-1:0]  slew_limit,
  output logic [slaf_pkg::FIELD_W-1:0] result
);

  localparam int SUM_W = SAMPLE_BITS + 3;

  logic [SAMPLE_BITS-1:0] last_output;
  logic [SAMPLE_BITS-1:0] history [slaf_pkg::HIST_DEPTH];
  logic                   reload_pending;

  logic [SAMPLE_BITS-1:0] x;
  logic [SAMPLE_BITS-1:0] diff_up;
  logic [SAMPLE_BITS-1:0] diff_dn;
  logic [SAMPLE_BITS-1:0] x_clamped;
  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_BITS-1:0] avg;

  always_comb begin
    x       = item.sample[SAMPLE_BITS-1:0];
    diff_up = x - last_output;
    diff_dn = last_output - x;

    // Clamp towards last_output; result always lies between the two
    x_clamped = x;
    if (x > last_output) begin
      if (slaf_pkg::SLEW_W'(diff_up) > slew_limit) begin
        x_clamped = last_output + SAMPLE_BITS'(slew_limit);
      end
    end else begin
      if (slaf_pkg::SLEW_W'(diff_dn) > slew_limit) begin
        x_clamped = last_output - SAMPLE_BITS'(slew_limit);
      end
    end

    sum = SUM_W'(x_clamped);
    for (int i = 0; i < slaf_pkg::HIST_DEPTH; i++) begin
      sum = sum + SUM_W'(history[i]);
    end

    // Round up only when the remainder exceeds four
    avg = sum[SUM_W-1:3] + SAMPLE_BITS'(sum[2:0] > 3'd4);

    if (reload_pending) begin
      result = slaf_pkg::FIELD_W'(x);
    end else begin
      result = slaf_pkg::FIELD_W'(avg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_pending <= 1'b1;
      last_output    <= '0;
      for (int i = 0; i < slaf_pkg::HIST_DEPTH; i++) begin
        history[i] <= '0;
      end
    end else if (fire) begin
      if (item.opcode == slaf_pkg::OP_RELOAD) begin
        reload_pending <= 1'b1;
      end else if (reload_pending) begin
        reload_pending <= 1'b0;
        last_output    <= x;
        for (int i = 0; i < slaf_pkg::HIST_DEPTH; i++) begin
          history[i] <= x;
        end
      end else begin
        last_output <= avg;
        history[0]  <= x_clamped;
        for (int i = 1; i < slaf_pkg::HIST_DEPTH; i++) begin
          history[i] <= history[i-1];
        end
      end
    end
  end

endmodule

>>> rtl/slaf_checker.sv
// Port-level checks for slew_limited_average_filter_core, bound to the top level.
// Depends on slaf_pkg.
module slaf_port_checks (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [slaf_pkg::FIELD_W-1:0]  filtered,
  input logic [slaf_pkg::APB_DW-1:0]   prdata,
  input logic                          pready
);

  // Output channel empties at reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  // A waiting word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(filtered)))
    else $error("stalled output word changed");

  // Input backs up only behind a stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  // Register port always ready, upper read bits zero
  a_apb_read: assert property (@(posedge clk)
    pready && (prdata[slaf_pkg::APB_DW-1:slaf_pkg::SLEW_W] == '0))
    else $error("configuration read bus malformed");

endmodule

bind slew_limited_average_filter_core slaf_port_checks u_slaf_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .filtered  (filtered),
  .prdata    (prdata),
  .pready    (pready)
);
